@@ hw/rtl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and word types of the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 12;
    localparam int SCORE_W    = 16;
    localparam int SRC_W      = 6;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd1;

    localparam logic [THR_W-1:0] THR_RESET = 9'd77;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_w;
        logic [COORD_BITS-1:0] box_h;
        logic [SCORE_W-1:0]    score;
        logic                  last_box;
    } t_box_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] kept_x;
        logic [COORD_BITS-1:0] kept_y;
        logic [COORD_BITS-1:0] kept_w;
        logic [COORD_BITS-1:0] kept_h;
        logic [SCORE_W-1:0]    kept_score;
        logic [SRC_W-1:0]      source_index;
        logic                  last_kept;
    } t_box_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_W-1:0]    score;
        logic [IDX_W-1:0]      idx;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    typedef struct packed {
        logic ld;
        logic shift;
    } t_cell_op;

endpackage

@@ hw/rtl/gbn_cell.sv @@
// ----------------------------------------------------------------------------
// gbn_cell
// One slot of the sorting row: takes the new box, its neighbour's box or
// keeps its own, so that the row stays in descending score order.
// ----------------------------------------------------------------------------
module gbn_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbn_pkg::t_cell_op i_op,
    input  gbn_pkg::t_entry   i_new,
    input  gbn_pkg::t_slot    i_prev,
    input  logic              i_prev_ins,
    input  gbn_pkg::t_slot    i_next,
    output gbn_pkg::t_slot    o_slot,
    output logic              o_ins
);

    gbn_pkg::t_slot r_slot;
    gbn_pkg::t_slot n_slot;

    assign o_ins  = !r_slot.valid || (r_slot.entry.score < i_new.score);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_op.shift) begin
            n_slot = i_next;
        end else if (i_op.ld && o_ins) begin
            if (i_prev_ins) begin
                n_slot = i_prev;
            end else begin
                n_slot.valid = 1'b1;
                n_slot.entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.entry <= n_slot.entry;
    end

endmodule

@@ hw/rtl/gbn_overlap.sv @@
// ----------------------------------------------------------------------------
// gbn_overlap
// Four-stage pipeline that decides whether a candidate box may stay next to
// one kept box under the overlap threshold.
// ----------------------------------------------------------------------------
module gbn_overlap (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  gbn_pkg::t_entry            i_good,
    input  gbn_pkg::t_entry            i_cand,
    input  logic [gbn_pkg::THR_W-1:0]  i_thr,
    input  logic                       i_mode,
    output logic                       o_valid,
    output logic                       o_ok
);

    localparam int EXT_W   = gbn_pkg::COORD_BITS + 1;
    localparam int AREA_W  = 2 * gbn_pkg::COORD_BITS;
    localparam int INTER_W = 2 * EXT_W;
    localparam int DEN_W   = INTER_W + 2;
    localparam int LHS_W   = INTER_W + 8;
    localparam int RHS_W   = gbn_pkg::THR_W + INTER_W;

    logic [3:0] r_vld;

    logic [EXT_W-1:0]   r_ex, r_ey;
    logic [AREA_W-1:0]  r_a1, r_a2, r_a1b, r_a2b;
    logic [INTER_W-1:0] r_inter;
    logic signed [DEN_W-1:0] r_den;
    logic [LHS_W-1:0]   r_lhs, r_lhs2;
    logic [RHS_W-1:0]   r_rhs;
    logic               r_pos;

    function automatic logic [EXT_W-1:0] ext(
        input logic [gbn_pkg::COORD_BITS-1:0] a0,
        input logic [gbn_pkg::COORD_BITS-1:0] al,
        input logic [gbn_pkg::COORD_BITS-1:0] b0,
        input logic [gbn_pkg::COORD_BITS-1:0] bl
    );
        logic [gbn_pkg::COORD_BITS-1:0] lo;
        logic [EXT_W-1:0] ea, eb, hi;
        logic signed [EXT_W+1:0] d;
        lo = (a0 > b0) ? a0 : b0;
        ea = EXT_W'(a0) + EXT_W'(al);
        eb = EXT_W'(b0) + EXT_W'(bl);
        hi = (ea < eb) ? ea : eb;
        d  = $signed({2'b00, hi}) - $signed({3'b000, lo}) + (EXT_W+2)'(1);
        ext = (d > 0) ? d[EXT_W-1:0] : '0;
    endfunction

    logic signed [DEN_W-1:0] n_den;

    always_comb begin
        if (i_mode) begin
            n_den = (r_a1b < r_a2b) ? $signed(DEN_W'(r_a1b)) : $signed(DEN_W'(r_a2b));
        end else begin
            n_den = $signed(DEN_W'(r_a1b)) + $signed(DEN_W'(r_a2b))
                  - $signed(DEN_W'(r_inter));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
        r_ex    <= ext(i_good.x, i_good.w, i_cand.x, i_cand.w);
        r_ey    <= ext(i_good.y, i_good.h, i_cand.y, i_cand.h);
        r_a1    <= i_good.w * i_good.h;
        r_a2    <= i_cand.w * i_cand.h;
        r_inter <= r_ex * r_ey;
        r_a1b   <= r_a1;
        r_a2b   <= r_a2;
        r_den   <= n_den;
        r_lhs   <= {r_inter, 8'd0};
        r_pos   <= (r_den > 0);
        r_rhs   <= i_thr * r_den[INTER_W-1:0];
        r_lhs2  <= r_lhs;
    end

    assign o_valid = r_vld[3];
    assign o_ok    = r_pos && (RHS_W'(r_lhs2) <= r_rhs);

endmodule

@@ hw/rtl/greedy_box_nms.sv @@
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over a set of scored boxes.
// ----------------------------------------------------------------------------
// Boxes load one per cycle while busy is low into a row of cells that keeps
// them sorted by descending score, ties in arrival order; boxes beyond the
// row's depth are dropped. A word with last_box set ends the set and raises
// busy. Each box is then taken from the head of the row and compared, one
// kept box at a time, with the boxes kept so far through a four-stage
// overlap pipeline, until one of them suppresses it. Each comparison passes
// through S_CHECK, S_READ and S_WAIT; a box is taken from the row in S_CAND
// and a kept box is stored in S_CHECK, and S_CAND finally finds the row empty.
// Kept boxes are then read out of the kept memory one per cycle on o_strobe;
// the receiver cannot stall them. busy falls in the cycle that shows the
// final kept box.
// ----------------------------------------------------------------------------
module greedy_box_nms (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  gbn_pkg::t_box_in                i_box,
    output logic                            o_strobe,
    output gbn_pkg::t_box_out               o_kept,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int N = gbn_pkg::MAX_BOXES;

    typedef enum logic [2:0] {
        S_LOAD, S_CAND, S_CHECK, S_READ, S_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [gbn_pkg::THR_W-1:0] r_thr;
    logic                      r_mode;
    logic [gbn_pkg::CNT_W-1:0] r_count, r_nk, r_k, r_oi;
    logic                      r_ov, r_olast;
    gbn_pkg::t_entry           r_cand, r_rd;
    gbn_pkg::t_entry           mem [N];

    gbn_pkg::t_slot   slots [N];
    logic             ins   [N];
    gbn_pkg::t_cell_op op;
    gbn_pkg::t_entry  new_e;
    logic             accept, ov_valid, ov_ok, launch, mem_we;
    logic [gbn_pkg::IDX_W-1:0] rd_addr;

    assign accept = i_start && (r_state == S_LOAD);
    assign o_busy = (r_state != S_LOAD);

    assign new_e.x     = i_box.box_x;
    assign new_e.y     = i_box.box_y;
    assign new_e.w     = i_box.box_w;
    assign new_e.h     = i_box.box_h;
    assign new_e.score = i_box.score;
    assign new_e.idx   = r_count[gbn_pkg::IDX_W-1:0];

    assign op.ld    = accept && (r_count < gbn_pkg::CNT_W'(N));
    assign op.shift = (r_state == S_CAND) && slots[0].valid;

    for (genvar g = 0; g < N; g++) begin : g_row
        gbn_pkg::t_slot prev_s, next_s;
        logic           prev_i;
        if (g == 0) begin : g_head
            assign prev_s = '0;
            assign prev_i = 1'b0;
        end else begin : g_body
            assign prev_s = slots[g-1];
            assign prev_i = ins[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign next_s = '0;
        end else begin : g_mid
            assign next_s = slots[g+1];
        end
        gbn_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (op),
            .i_new      (new_e),
            .i_prev     (prev_s),
            .i_prev_ins (prev_i),
            .i_next     (next_s),
            .o_slot     (slots[g]),
            .o_ins      (ins[g])
        );
    end

    assign launch = (r_state == S_READ);

    gbn_overlap u_overlap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (launch),
        .i_good  (r_rd),
        .i_cand  (r_cand),
        .i_thr   (r_thr),
        .i_mode  (r_mode),
        .o_valid (ov_valid),
        .o_ok    (ov_ok)
    );

    assign mem_we  = (r_state == S_CHECK) && (r_k == r_nk);
    assign rd_addr = (r_state == S_OUT) ? r_oi[gbn_pkg::IDX_W-1:0]
                                        : r_k[gbn_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_nk[gbn_pkg::IDX_W-1:0]] <= r_cand;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_thr   <= gbn_pkg::THR_RESET;
            r_mode  <= 1'b0;
            r_count <= '0;
            r_nk    <= '0;
            r_k     <= '0;
            r_oi    <= '0;
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gbn_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data[gbn_pkg::THR_W-1:0];
                    gbn_pkg::CFG_MODE:      r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (op.ld) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_box.last_box) begin
                            r_count <= '0;
                            r_nk    <= '0;
                            r_state <= S_CAND;
                        end
                    end
                end
                S_CAND: begin
                    if (slots[0].valid) begin
                        r_cand  <= slots[0].entry;
                        r_k     <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_oi    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_CHECK: begin
                    if (r_k == r_nk) begin
                        r_nk    <= r_nk + 1'b1;
                        r_state <= S_CAND;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (ov_valid) begin
                        if (ov_ok) begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_CAND;
                        end
                    end
                end
                S_OUT: begin
                    r_ov    <= 1'b1;
                    r_olast <= (r_oi == r_nk - 1'b1);
                    if (r_oi == r_nk - 1'b1) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_oi <= r_oi + 1'b1;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_strobe            = r_ov;
    assign o_kept.kept_x       = r_rd.x;
    assign o_kept.kept_y       = r_rd.y;
    assign o_kept.kept_w       = r_rd.w;
    assign o_kept.kept_h       = r_rd.h;
    assign o_kept.kept_score   = r_rd.score;
    assign o_kept.source_index = gbn_pkg::SRC_W'(r_rd.idx);
    assign o_kept.last_kept    = r_olast;

endmodule

@@ hw/rtl/gbn_checker.sv @@
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the suppression block over time, bound to its top.
// ----------------------------------------------------------------------------
module gbn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input gbn_pkg::t_box_in  i_box,
    input logic              o_strobe,
    input gbn_pkg::t_box_out o_kept
);

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_box.last_box |=> o_busy)
        else $error("final word of a set did not start processing");

    a_burst_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_kept.last_kept |=> o_strobe)
        else $error("gap inside a burst of kept boxes");

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kept.last_kept |=> !o_strobe)
        else $error("kept box after the final one of a set");

    a_done_shows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_strobe && o_kept.last_kept)
        else $error("processing ended without the final kept box");

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_box    (i_box),
    .o_strobe (o_strobe),
    .o_kept   (o_kept)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy box suppression block.
// ----------------------------------------------------------------------------
// Sets of scored boxes are loaded through the start/busy handshake. A model
// inside the bench sorts each set by score, applies the greedy overlap test
// and queues the kept boxes, which are compared field by field with every
// word seen on o_strobe. A directed table covers the field extremes and
// zero-area boxes, and a loop the overflow of the store; random sets with
// clustered boxes follow in both overlap modes and several threshold settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct {
        gbn_pkg::t_box_in  box;
        logic              chk;
        gbn_pkg::t_box_out want;
    } t_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    gbn_pkg::t_box_in  box_in = '0;
    logic              strobe;
    gbn_pkg::t_box_out kept_out;
    logic              cfg_we = 1'b0;
    logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    gbn_pkg::t_box_out kept_queue[$];
    gbn_pkg::t_box_out typed_queue[$];
    gbn_pkg::t_box_in  set_boxes[$];
    logic [gbn_pkg::THR_W-1:0] thr_q;
    logic                      mode_q;
    int errors = 0;
    int boxes_sent = 0;
    int words_seen = 0;
    int sets_done = 0;
    int idle_count = 0;
    bit quiet = 1'b0;

    greedy_box_nms u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_box      (box_in),
        .o_strobe   (strobe),
        .o_kept     (kept_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint span(longint a0, longint alen, longint b0, longint blen);
        longint lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + alen) < (b0 + blen)) ? a0 + alen : b0 + blen;
        return (hi - lo + 1 > 0) ? hi - lo + 1 : 0;
    endfunction

    function automatic bit may_coexist(gbn_pkg::t_box_in g, gbn_pkg::t_box_in c);
        longint inter, ag, ac, den;
        inter = span(longint'(g.box_x), longint'(g.box_w),
                     longint'(c.box_x), longint'(c.box_w)) *
                span(longint'(g.box_y), longint'(g.box_h),
                     longint'(c.box_y), longint'(c.box_h));
        ag = longint'(g.box_w) * longint'(g.box_h);
        ac = longint'(c.box_w) * longint'(c.box_h);
        den = mode_q ? ((ag < ac) ? ag : ac) : ag + ac - inter;
        if (den <= 0) return 1'b0;
        return inter * 256 <= longint'(thr_q) * den;
    endfunction

    // Store one box; on the last word of a set, predict the kept boxes.
    task automatic predict_kept(gbn_pkg::t_box_in b);
        int order[$];
        int kept[$];
        int n, j, v;
        bit keep;
        gbn_pkg::t_box_out o;
        if (set_boxes.size() < gbn_pkg::MAX_BOXES) set_boxes.insert(set_boxes.size(), b);
        if (!b.last_box) return;
        n = set_boxes.size();
        for (int i = 0; i < n; i++) begin
            j = order.size();
            while (j > 0 && set_boxes[order[j-1]].score < set_boxes[i].score) j--;
            order.insert(j, i);
        end
        for (int i = 0; i < n; i++) begin
            keep = 1'b1;
            foreach (kept[k])
                if (keep && !may_coexist(set_boxes[kept[k]], set_boxes[order[i]]))
                    keep = 1'b0;
            if (keep) kept.insert(kept.size(), order[i]);
        end
        foreach (kept[k]) begin
            v = kept[k];
            o.kept_x = set_boxes[v].box_x;
            o.kept_y = set_boxes[v].box_y;
            o.kept_w = set_boxes[v].box_w;
            o.kept_h = set_boxes[v].box_h;
            o.kept_score = set_boxes[v].score;
            o.source_index = v[gbn_pkg::SRC_W-1:0];
            o.last_kept = (k == kept.size() - 1);
            kept_queue.insert(kept_queue.size(), o);
        end
        set_boxes.delete();
    endtask

    always @(posedge clk) begin
        if (rst_n && strobe) begin
            gbn_pkg::t_box_out w, t;
            words_seen++;
            if (kept_queue.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %p", $time, kept_out);
                errors++;
            end else begin
                w = kept_queue.pop_front();
                if (typed_queue.size() > 0) begin
                    t = typed_queue.pop_front();
                    if (t !== w) begin
                        $display("%0t: table row disagrees, expected %p, actual %p",
                                 $time, t, w);
                        errors++;
                    end
                end
                if (kept_out.kept_x !== w.kept_x || kept_out.kept_y !== w.kept_y ||
                    kept_out.kept_w !== w.kept_w || kept_out.kept_h !== w.kept_h ||
                    kept_out.kept_score !== w.kept_score ||
                    kept_out.source_index !== w.source_index ||
                    kept_out.last_kept !== w.last_kept) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, w, kept_out);
                    errors++;
                end
                if (w.last_kept) sets_done++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || strobe || (start && !busy) || cfg_we) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_box(gbn_pkg::t_box_in b);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        box_in <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_kept(b);
        boxes_sent++;
    endtask

    task automatic write_cfg(logic [gbn_pkg::CFG_IDX_W-1:0] idx,
                             logic [gbn_pkg::CFG_DATA_W-1:0] val);
        start <= 1'b0;
        while (kept_queue.size() > 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gbn_pkg::CFG_THRESHOLD) thr_q = val;
        else mode_q = val[0];
    endtask

    function automatic gbn_pkg::t_box_in mk(int x, int y, int w, int h, int s, bit l);
        gbn_pkg::t_box_in b;
        b.box_x = gbn_pkg::COORD_BITS'(x);
        b.box_y = gbn_pkg::COORD_BITS'(y);
        b.box_w = gbn_pkg::COORD_BITS'(w);
        b.box_h = gbn_pkg::COORD_BITS'(h);
        b.score = gbn_pkg::SCORE_W'(s);
        b.last_box = l;
        return b;
    endfunction

    function automatic gbn_pkg::t_box_out ko(gbn_pkg::t_box_in b, int src, bit l);
        gbn_pkg::t_box_out o;
        o.kept_x = b.box_x; o.kept_y = b.box_y; o.kept_w = b.box_w;
        o.kept_h = b.box_h; o.kept_score = b.score;
        o.source_index = gbn_pkg::SRC_W'(src); o.last_kept = l;
        return o;
    endfunction

    task automatic random_set(int n);
        int cx, cy;
        gbn_pkg::t_box_in b;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: b = mk($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0);
                1: b = mk($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 2), $urandom_range(0, 2), 0, 0);
                default: b = mk((cx + $urandom_range(0, 40)) % 4096,
                                (cy + $urandom_range(0, 40)) % 4096,
                                $urandom_range(1, 80), $urandom_range(1, 80), 0, 0);
            endcase
            b.score = ($urandom_range(0, 3) == 0)
                    ? gbn_pkg::SCORE_W'($urandom_range(0, 3) << 14)
                    : gbn_pkg::SCORE_W'($urandom_range(0, 65535));
            b.last_box = (i == n - 1);
            send_box(b);
        end
    endtask

    initial begin
        t_row rows[$];
        gbn_pkg::t_box_in b0, b1;
        int left;
        thr_q = gbn_pkg::THR_RESET;
        mode_q = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single boxes at the field extremes are always kept.
        b0 = mk(0, 0, 0, 0, 0, 1);
        rows.insert(rows.size(), '{b0, 1'b1, ko(b0, 0, 1)});
        b0 = mk(4095, 4095, 4095, 4095, 65535, 1);
        rows.insert(rows.size(), '{b0, 1'b1, ko(b0, 0, 1)});
        // Identical boxes with equal score: the first arrival wins.
        b0 = mk(100, 100, 50, 50, 1000, 0);
        rows.insert(rows.size(), '{b0, 1'b0, '0});
        b1 = mk(100, 100, 50, 50, 1000, 1);
        rows.insert(rows.size(), '{b1, 1'b1, ko(b0, 0, 1)});
        // Disjoint boxes, higher score later.
        rows.insert(rows.size(), '{mk(0, 0, 10, 10, 5, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk(2000, 2000, 10, 10, 9, 1), 1'b0, '0});
        // A zero-area box after a kept box is suppressed.
        rows.insert(rows.size(), '{mk(10, 10, 0, 0, 300, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk(3000, 3000, 0, 5, 200, 1), 1'b0, '0});
        // Partial overlap, alternating bits.
        rows.insert(rows.size(),
                    '{mk(12'hAAA, 12'h555, 12'h0AA, 12'h055, 16'hAAAA, 0), 1'b0, '0});
        rows.insert(rows.size(),
                    '{mk(12'h555, 12'hAAA, 12'h055, 12'h0AA, 16'h5555, 0), 1'b0, '0});
        rows.insert(rows.size(),
                    '{mk(12'hAB0, 12'h560, 12'h0A0, 12'h050, 16'hAAAA, 1), 1'b0, '0});
        foreach (rows[r]) begin
            if (rows[r].chk) typed_queue.insert(typed_queue.size(), rows[r].want);
            send_box(rows[r].box);
        end

        // Overflow: more boxes than the store holds, last flag on a dropped box.
        for (int i = 0; i < gbn_pkg::MAX_BOXES + 2; i++)
            send_box(mk(i * 60, i * 60, 20, 20, $urandom_range(0, 65535),
                        i == gbn_pkg::MAX_BOXES + 1));

        write_cfg(gbn_pkg::CFG_MODE, gbn_pkg::CFG_DATA_W'(1));
        write_cfg(gbn_pkg::CFG_THRESHOLD, gbn_pkg::CFG_DATA_W'(0));
        random_set(6);
        write_cfg(gbn_pkg::CFG_THRESHOLD, gbn_pkg::CFG_DATA_W'(256));
        random_set(6);
        write_cfg(gbn_pkg::CFG_THRESHOLD, gbn_pkg::CFG_DATA_W'(511));
        random_set(6);

        for (int p = 0; p < 6; p++) begin
            write_cfg(gbn_pkg::CFG_MODE, gbn_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            write_cfg(gbn_pkg::CFG_THRESHOLD,
                      gbn_pkg::CFG_DATA_W'((p == 0) ? 0 : (p == 1) ? 511
                                                     : $urandom_range(0, 300)));
            left = 55;
            while (left > 0) begin
                int n;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10);
                if (p == 5 && left < 20) quiet = 1'b1;
                random_set(n);
                left -= n;
            end
        end

        start <= 1'b0;
        while (kept_queue.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Loaded %0d boxes in %0d sets; checked %0d kept words.",
                 boxes_sent, sets_done, words_seen);
        $display("Thresholds 0, 256, 511 and random, both overlap modes, store overflow.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
